FILE: rtl/core/pgacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgacc_pkg
// Shared types and constants of the pairwise gravity accumulate unit.
// ----------------------------------------------------------------------------
package pgacc_pkg;

    // Default gravitational constant, integer part.
    localparam int unsigned G_DEFAULT_INT = 600;

    // Operand and result widths of the shared arithmetic unit.
    localparam int unsigned OPA_W = 96;
    localparam int unsigned OPB_W = 66;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_rsp;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_ZERO_DIST = 2'd1,
        ERR_ZERO_MASS = 2'd2
    } t_err;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic        [31:0] target_mass;
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic signed [31:0] source_z;
        logic        [31:0] source_mass;
        logic               first_pair;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] force_x;
        logic signed [63:0] force_y;
        logic signed [63:0] force_z;
        logic signed [63:0] accel_x;
        logic signed [63:0] accel_y;
        logic signed [63:0] accel_z;
        logic        [1:0]  error_code;
    } t_out_item;

endpackage

FILE: rtl/core/pgacc_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgacc_alu
// Bit-serial shared unit: shift-add multiply, restoring divide, digit square root.
// ----------------------------------------------------------------------------
module pgacc_alu
    import pgacc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_alu_req         i_req,
    input  logic [OPA_W-1:0] i_opa,
    input  logic [OPB_W-1:0] i_opb,
    output t_alu_rsp         o_rsp,
    output logic [OPA_W-1:0] o_result
);

    localparam logic [6:0] MUL_STEPS  = 7'd32;
    localparam logic [6:0] DIV_STEPS  = 7'd96;
    localparam logic [6:0] SQRT_STEPS = 7'd33;

    t_alu_op          r_op;
    logic             r_busy;
    logic             r_done;
    logic [6:0]       r_cnt;
    logic [OPA_W-1:0] r_x;
    logic [OPB_W-1:0] r_y;
    logic [OPA_W-1:0] r_acc;
    logic [66:0]      r_rem;

    logic [66:0] div_t;
    logic        div_ge;
    logic [35:0] sq_t;
    logic [35:0] sq_trial;
    logic        sq_ge;

    always_comb begin
        div_t    = {r_rem[65:0], r_x[OPA_W-1]};
        div_ge   = div_t >= {1'b0, r_y};
        sq_t     = {r_rem[33:0], r_x[65:64]};
        sq_trial = {1'b0, r_y[32:0], 2'b01};
        sq_ge    = sq_t >= sq_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_x    <= i_opa;
                r_acc  <= '0;
                r_rem  <= '0;
                case (i_req.op)
                    OP_MUL: begin
                        r_y   <= i_opb;
                        r_cnt <= MUL_STEPS - 7'd1;
                    end
                    OP_DIV: begin
                        r_y   <= i_opb;
                        r_cnt <= DIV_STEPS - 7'd1;
                    end
                    default: begin
                        r_y   <= '0;
                        r_cnt <= SQRT_STEPS - 7'd1;
                    end
                endcase
            end else if (r_busy) begin
                case (r_op)
                    OP_MUL: begin
                        if (r_y[0]) begin
                            r_acc <= r_acc + r_x;
                        end
                        r_x <= {r_x[OPA_W-2:0], 1'b0};
                        r_y <= {1'b0, r_y[OPB_W-1:1]};
                    end
                    OP_DIV: begin
                        r_rem <= div_ge ? (div_t - {1'b0, r_y}) : div_t;
                        r_x   <= {r_x[OPA_W-2:0], div_ge};
                    end
                    default: begin
                        r_rem <= {31'b0, sq_ge ? (sq_t - sq_trial) : sq_t};
                        r_y   <= {r_y[OPB_W-2:0], sq_ge};
                        r_x   <= {r_x[OPA_W-3:0], 2'b00};
                    end
                endcase
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.busy = r_busy;
        o_rsp.done = r_done;
        case (r_op)
            OP_MUL:  o_result = r_acc;
            OP_DIV:  o_result = r_x;
            default: o_result = {63'b0, r_y[32:0]};
        endcase
    end

endmodule

FILE: rtl/core/pairwise_gravity_accumulate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pairwise_gravity_accumulate_unit
// Gravitational force of a source body on a target, with acceleration sum.
// ----------------------------------------------------------------------------
// Usage. The input channel carries one body pair per transfer: target and
// source positions and masses and the first_pair flag. The output channel
// carries one result per pair: the force on the target, the acceleration
// sum after this pair and an error code. Both channels use valid and stall.
// The gravitational constant is written through the APB-style port at byte
// address 0; it may only be changed while the block is idle.
// Work: each pair is computed step by step in the shared bit-serial unit,
// which yields one product bit, one quotient bit or one root digit each
// cycle: three squares, two mass products, a force division, a square root,
// and per axis one product and two 96-step divisions. A pair that ends in
// an error stops after the three squares.
// One pair is worked at a time; the input is stalled until the sequencer is
// idle again. A finished result sits in an output register, so the next pair
// may be taken while the receiver stalls; that pair then waits to be shown.
// Reset clears the acceleration sum, empties the output register and loads
// the default constant of 600, scaled by FRAC_BITS and saturated to 32 bits.
// ----------------------------------------------------------------------------
module pairwise_gravity_accumulate_unit
    import pgacc_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Default constant, saturated to 32 bits for large fraction widths.
    localparam logic [63:0] G_WIDE  = 64'(G_DEFAULT_INT) << FRAC_BITS;
    localparam logic [31:0] G_RESET = (G_WIDE > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                               : G_WIDE[31:0];
    localparam logic [63:0] SMAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN    = 64'h8000_0000_0000_0001;

    typedef enum logic [11:0] {
        ST_IDLE = 12'b0000_0000_0001,
        ST_SQ   = 12'b0000_0000_0010,
        ST_CHK  = 12'b0000_0000_0100,
        ST_GM1  = 12'b0000_0000_1000,
        ST_GM2  = 12'b0000_0001_0000,
        ST_DIVF = 12'b0000_0010_0000,
        ST_ROOT = 12'b0000_0100_0000,
        ST_FM   = 12'b0000_1000_0000,
        ST_FD   = 12'b0001_0000_0000,
        ST_AD   = 12'b0010_0000_0000,
        ST_ACC  = 12'b0100_0000_0000,
        ST_OUT  = 12'b1000_0000_0000
    } t_state;

    // Saturate an unsigned quotient to the largest positive 64-bit value.
    function automatic logic [62:0] sat63(input logic [OPA_W-1:0] q);
        sat63 = (q[OPA_W-1:63] != '0) ? SMAX[62:0] : q[62:0];
    endfunction

    // Saturating signed add.
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            sat_add = a[63] ? SMIN : SMAX;
        end else begin
            sat_add = s;
        end
    endfunction

    t_state r_state, n_state;
    logic   r_go;
    logic [1:0] r_c;

    logic [31:0] r_g;
    logic [31:0] r_mag [3];
    logic        r_neg [3];
    logic [31:0] r_tm;
    logic [31:0] r_sm;
    logic [65:0] r_s;
    logic [OPA_W-1:0] r_t;
    logic [62:0] r_f;
    logic [32:0] r_d;
    logic [62:0] r_fm;
    logic [62:0] r_am;
    logic [63:0] r_force [3];
    logic [63:0] r_accum [3];
    t_err        r_err;

    logic      r_out_valid;
    t_out_item r_out;

    t_alu_req         alu_req;
    t_alu_rsp         alu_rsp;
    logic [OPA_W-1:0] alu_a;
    logic [OPB_W-1:0] alu_b;
    logic [OPA_W-1:0] alu_res;

    logic        in_acc;
    logic        out_free;
    logic [32:0] dlt [3];
    logic        fneg;
    logic [63:0] am_signed;

    pgacc_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_opa    (alu_a),
        .i_opb    (alu_b),
        .o_rsp    (alu_rsp),
        .o_result (alu_res)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = paddr[2] ? 32'd0 : r_g;

    always_comb begin
        dlt[0] = {i_in_data.target_x[31], i_in_data.target_x}
               - {i_in_data.source_x[31], i_in_data.source_x};
        dlt[1] = {i_in_data.target_y[31], i_in_data.target_y}
               - {i_in_data.source_y[31], i_in_data.source_y};
        dlt[2] = {i_in_data.target_z[31], i_in_data.target_z}
               - {i_in_data.source_z[31], i_in_data.source_z};
        // The force points from target to source: opposite to the delta.
        fneg      = !r_neg[r_c] && (r_mag[r_c] != 32'd0);
        am_signed = fneg ? (64'd0 - {1'b0, r_am}) : {1'b0, r_am};
    end

    // Operand selection for the shared unit.
    always_comb begin
        alu_req.start = r_go;
        alu_req.op    = OP_MUL;
        alu_a         = '0;
        alu_b         = '0;
        case (r_state)
            ST_SQ: begin
                alu_a = {64'b0, r_mag[r_c]};
                alu_b = {34'b0, r_mag[r_c]};
            end
            ST_GM1: begin
                alu_a = {64'b0, r_g};
                alu_b = {34'b0, r_tm};
            end
            ST_GM2: begin
                alu_a = {32'b0, r_t[63:0]};
                alu_b = {34'b0, r_sm};
            end
            ST_DIVF: begin
                alu_req.op = OP_DIV;
                alu_a      = r_t;
                alu_b      = r_s;
            end
            ST_ROOT: begin
                alu_req.op = OP_SQRT;
                alu_a      = {30'b0, r_s};
            end
            ST_FM: begin
                alu_a = {33'b0, r_f};
                alu_b = {34'b0, r_mag[r_c]};
            end
            ST_FD: begin
                alu_req.op = OP_DIV;
                alu_a      = r_t;
                alu_b      = {33'b0, r_d};
            end
            ST_AD: begin
                alu_req.op = OP_DIV;
                alu_a      = {33'b0, r_fm} << FRAC_BITS;
                alu_b      = {34'b0, r_tm};
            end
            default: begin
                alu_req.op = OP_MUL;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_acc) n_state = ST_SQ;
            ST_SQ:   if (alu_rsp.done && r_c == 2'd2) n_state = ST_CHK;
            ST_CHK: begin
                if (r_s == '0 || r_tm == 32'd0) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_GM1;
                end
            end
            ST_GM1:  if (alu_rsp.done) n_state = ST_GM2;
            ST_GM2:  if (alu_rsp.done) n_state = ST_DIVF;
            ST_DIVF: if (alu_rsp.done) n_state = ST_ROOT;
            ST_ROOT: if (alu_rsp.done) n_state = ST_FM;
            ST_FM:   if (alu_rsp.done) n_state = ST_FD;
            ST_FD:   if (alu_rsp.done) n_state = ST_AD;
            ST_AD:   if (alu_rsp.done) n_state = ST_ACC;
            ST_ACC:  n_state = (r_c == 2'd2) ? ST_OUT : ST_FM;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_go        <= 1'b0;
            r_c         <= 2'd0;
            r_g         <= G_RESET;
            r_out_valid <= 1'b0;
            r_err       <= ERR_NONE;
            for (int i = 0; i < 3; i++) begin
                r_accum[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_go    <= 1'b0;

            if (psel && penable && pwrite && !paddr[2]) begin
                r_g <= pwdata;
            end

            // The result register fills from the sequencer and empties on a
            // transfer to the receiver.
            r_out_valid <= (r_state == ST_OUT && out_free) || (r_out_valid && i_out_stall);

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i]   <= dlt[i][32];
                            r_mag[i]   <= dlt[i][32] ? 32'(33'd0 - dlt[i]) : dlt[i][31:0];
                            r_force[i] <= '0;
                            if (i_in_data.first_pair) begin
                                r_accum[i] <= '0;
                            end
                        end
                        r_tm  <= i_in_data.target_mass;
                        r_sm  <= i_in_data.source_mass;
                        r_s   <= '0;
                        r_c   <= 2'd0;
                        r_err <= ERR_NONE;
                        r_go  <= 1'b1;
                    end
                end
                ST_SQ: begin
                    if (alu_rsp.done) begin
                        r_s <= r_s + {2'b0, alu_res[63:0]};
                        if (r_c == 2'd2) begin
                            r_c <= 2'd0;
                        end else begin
                            r_c  <= r_c + 2'd1;
                            r_go <= 1'b1;
                        end
                    end
                end
                ST_CHK: begin
                    if (r_s == '0) begin
                        r_err <= ERR_ZERO_DIST;
                    end else if (r_tm == 32'd0) begin
                        r_err <= ERR_ZERO_MASS;
                    end else begin
                        r_go <= 1'b1;
                    end
                end
                ST_GM1, ST_GM2, ST_FM: begin
                    if (alu_rsp.done) begin
                        r_t  <= alu_res;
                        r_go <= 1'b1;
                    end
                end
                ST_DIVF: begin
                    if (alu_rsp.done) begin
                        r_f  <= sat63(alu_res);
                        r_go <= 1'b1;
                    end
                end
                ST_ROOT: begin
                    if (alu_rsp.done) begin
                        r_d  <= alu_res[32:0];
                        r_go <= 1'b1;
                    end
                end
                ST_FD: begin
                    if (alu_rsp.done) begin
                        r_fm <= sat63(alu_res);
                        r_go <= 1'b1;
                    end
                end
                ST_AD: begin
                    if (alu_rsp.done) begin
                        r_am <= sat63(alu_res);
                    end
                end
                ST_ACC: begin
                    r_force[r_c] <= fneg ? (64'd0 - {1'b0, r_fm}) : {1'b0, r_fm};
                    r_accum[r_c] <= sat_add(r_accum[r_c], am_signed);
                    if (r_c != 2'd2) begin
                        r_c  <= r_c + 2'd1;
                        r_go <= 1'b1;
                    end
                end
                default: begin
                    r_go <= 1'b0;
                end
            endcase
        end
    end

    // Result register, loaded when the sequencer hands over a finished pair.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out.force_x    <= r_force[0];
            r_out.force_y    <= r_force[1];
            r_out.force_z    <= r_force[2];
            r_out.accel_x    <= r_accum[0];
            r_out.accel_y    <= r_accum[1];
            r_out.accel_z    <= r_accum[2];
            r_out.error_code <= r_err;
        end
    end

`ifndef SYNTHESIS
    a_stall_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled while a pair is in work");

    a_err_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error_code != ERR_NONE) |->
        (o_out_data.force_x == '0 && o_out_data.force_y == '0 &&
         o_out_data.force_z == '0))
        else $error("error result carries a force");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_req.start |-> !alu_rsp.busy)
        else $error("shared unit started while busy");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");
`endif

endmodule

FILE: tb/sv/tb_pairwise_gravity_accumulate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pairwise_gravity_accumulate_unit
// Self-checking bench for the pairwise gravity accumulate unit.
// ----------------------------------------------------------------------------
// A short table of directed body pairs is followed by random pairs in several
// phases. Each phase loads the gravitational constant while the block is idle
// and sets how often the sender idles and the receiver stalls. Every accepted
// pair is run through an exact 128-bit model of the force and acceleration
// arithmetic. Every accepted result is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_pairwise_gravity_accumulate_unit;
    import pgacc_pkg::*;

    localparam int          FRAC = 16;
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          LIMIT = 4_000_000;
    localparam int          N_PHASES = 7;
    localparam int          PHASE_ITEMS = 100;
    localparam logic [2:0]  ADDR_GRAVITY = 3'd0;

    typedef struct {
        t_in_item  pair;
        bit        typed;    // expected result given in the table
        t_out_item result;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic [31:0] prdata;
    logic        pready;

    pairwise_gravity_accumulate_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Model state: the constant as written and the three acceleration sums.
    logic        [31:0] grav_const;
    logic signed [63:0] accel_acc [3];

    t_row      pairs_to_send [$];
    t_out_item results_due [$];
    int        send_idle = 0;
    int        recv_idle = 0;
    int        n_fail = 0;
    int        n_cycles = 0;

    function automatic logic [63:0] sat64(logic [127:0] q);
        return (q > 128'(SMAX)) ? SMAX : q[63:0];
    endfunction

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            return a[63] ? 64'h8000_0000_0000_0001 : SMAX;
        return r;
    endfunction

    function automatic logic [127:0] floor_root(logic [127:0] s);
        logic [127:0] r;
        logic [127:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= s) r = t;
        end
        return r;
    endfunction

    // Force of the source on the target and the updated acceleration sums.
    function automatic t_out_item gravity_pair(t_in_item p);
        logic signed [32:0] dlt [3];
        logic        [32:0] mag [3];
        logic [127:0] s;
        logic [127:0] f;
        logic [127:0] root;
        logic [63:0]  fm;
        logic [63:0]  am;
        logic [63:0]  fc [3];
        bit           fneg;
        t_out_item    r;
        dlt[0] = p.target_x - p.source_x;
        dlt[1] = p.target_y - p.source_y;
        dlt[2] = p.target_z - p.source_z;
        s = '0;
        for (int c = 0; c < 3; c++) begin
            mag[c] = dlt[c] < 0 ? 33'(-dlt[c]) : 33'(dlt[c]);
            s += 128'(mag[c]) * 128'(mag[c]);
            fc[c] = '0;
        end
        if (p.first_pair) begin
            for (int c = 0; c < 3; c++) accel_acc[c] = '0;
        end
        if (s == 0) begin
            r.error_code = ERR_ZERO_DIST;
        end else if (p.target_mass == 0) begin
            r.error_code = ERR_ZERO_MASS;
        end else begin
            r.error_code = ERR_NONE;
            f = 128'(sat64(128'(grav_const) * 128'(p.target_mass) * 128'(p.source_mass) / s));
            root = floor_root(s);
            for (int c = 0; c < 3; c++) begin
                fm = sat64(f * 128'(mag[c]) / root);
                am = sat64((128'(fm) << FRAC) / 128'(p.target_mass));
                // The force pulls the target towards the source.
                fneg = !(dlt[c] < 0) && mag[c] != 0;
                fc[c] = fneg ? -fm : fm;
                accel_acc[c] = sat_sum(accel_acc[c], fneg ? -am : am);
            end
        end
        r.force_x = fc[0];
        r.force_y = fc[1];
        r.force_z = fc[2];
        r.accel_x = accel_acc[0];
        r.accel_y = accel_acc[1];
        r.accel_z = accel_acc[2];
        return r;
    endfunction

    function automatic t_in_item mk_pair(
        logic [31:0] tx, logic [31:0] ty, logic [31:0] tz, logic [31:0] tm,
        logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, logic [31:0] sm,
        logic fp);
        t_in_item p;
        p.target_x = tx;  p.target_y = ty;  p.target_z = tz;  p.target_mass = tm;
        p.source_x = sx;  p.source_y = sy;  p.source_z = sz;  p.source_mass = sm;
        p.first_pair = fp;
        return p;
    endfunction

    function automatic t_row untyped_row(t_in_item p);
        t_row w;
        w.pair = p;
        w.typed = 1'b0;
        w.result = '0;
        return w;
    endfunction

    function automatic t_row error_row(t_in_item p, t_err e);
        t_row w;
        w.pair = p;
        w.typed = 1'b1;
        w.result = '0;
        w.result.error_code = e;
        return w;
    endfunction

    // Mostly a source near the target with random masses; the rest are
    // coincident bodies, massless targets and fully random bit patterns.
    function automatic t_in_item random_pair();
        t_in_item    p;
        int          kind;
        logic [31:0] off [3];
        kind = $urandom_range(99);
        p = mk_pair($urandom, $urandom, $urandom, $urandom >> $urandom_range(31),
                    $urandom, $urandom, $urandom, $urandom >> $urandom_range(31),
                    $urandom_range(7) == 0);
        if (kind < 78) begin
            for (int c = 0; c < 3; c++)
                off[c] = $urandom_range(3) == 0 ? 32'd0
                       : 32'($signed($urandom) >>> $urandom_range(31));
            p.source_x = p.target_x - off[0];
            p.source_y = p.target_y - off[1];
            p.source_z = p.target_z - off[2];
        end else if (kind < 86) begin
            p.source_x = p.target_x;
            p.source_y = p.target_y;
            p.source_z = p.target_z;
        end else if (kind < 92) begin
            p.target_mass = '0;
        end
        return p;
    endfunction

    // Sender: the head of the queue is shown until its transfer completes.
    always @(posedge i_clk) begin
        t_out_item r;
        bit        drive;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            drive = in_valid;
            if (in_valid && !o_in_stall) begin
                r = gravity_pair(pairs_to_send[0].pair);
                results_due = {results_due,
                               pairs_to_send[0].typed ? pairs_to_send[0].result : r};
                void'(pairs_to_send.pop_front());
                drive = 1'b0;
            end
            if (!(in_valid && o_in_stall))
                drive = pairs_to_send.size() > 0 && $urandom_range(99) >= send_idle;
            in_valid <= drive;
            if (drive) in_data <= pairs_to_send[0].pair;
        end
    end

    // Receiver: random stalls, and a field-wise check of each transfer.
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (results_due.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected result %h", o_out_data);
                end else begin
                    e = results_due.pop_front();
                    if (o_out_data !== e) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("mismatch force exp %h %h %h got %h %h %h",
                                     e.force_x, e.force_y, e.force_z, o_out_data.force_x,
                                     o_out_data.force_y, o_out_data.force_z);
                            $display("  accel exp %h %h %h got %h %h %h  err exp %0d got %0d",
                                     e.accel_x, e.accel_y, e.accel_z, o_out_data.accel_x,
                                     o_out_data.accel_y, o_out_data.accel_z, e.error_code,
                                     o_out_data.error_code);
                        end
                    end
                end
            end
            out_stall <= $urandom_range(99) < recv_idle;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT) begin
            $display("tb_pairwise_gravity_accumulate_unit NOT OK");
            $finish;
        end
    end

    // Setup and access cycles of one register write.
    task automatic write_gravity(logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_GRAVITY;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        grav_const = value;
    endtask

    task automatic drain();
        wait (pairs_to_send.size() == 0 && results_due.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        t_row        dir_rows [$];
        logic [31:0] g_list [N_PHASES];
        grav_const = 32'(G_DEFAULT_INT << FRAC);
        for (int c = 0; c < 3; c++) accel_acc[c] = '0;

        // Directed pairs, with the reset value of the constant.
        dir_rows = {dir_rows, error_row(mk_pair(5, 6, 7, 32'h1_0000, 5, 6, 7, 32'h1_0000, 1),
                                        ERR_ZERO_DIST)};
        dir_rows = {dir_rows, error_row(mk_pair(32'h1_0000, 0, 0, 0, 0, 0, 0, 32'h1_0000, 1),
                                        ERR_ZERO_MASS)};
        // Both errors at once: zero distance wins.
        dir_rows = {dir_rows, error_row(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 1), ERR_ZERO_DIST)};
        dir_rows = {dir_rows, untyped_row(mk_pair(32'h1_0000, 0, 0, 32'h1_0000,
                                                  0, 0, 0, 32'h1_0000, 1))};
        dir_rows = {dir_rows, untyped_row(mk_pair(0, 32'hFFFF_0000, 0, 32'h2_0000,
                                                  0, 0, 0, 32'h3_0000, 0))};
        dir_rows = {dir_rows, untyped_row(mk_pair(0, 0, 32'h8_0000, 32'h1_0000,
                                                  0, 0, 32'hFFF8_0000, 32'h10_0000, 0))};
        // Coincident bodies without a clear keep the sums as they are.
        dir_rows = {dir_rows, untyped_row(mk_pair(9, 9, 9, 32'h1_0000, 9, 9, 9,
                                                  32'h1_0000, 0))};
        dir_rows = {dir_rows, untyped_row(mk_pair(0, 0, 0, 0, 1, 1, 1, 32'hFFFF_FFFF, 0))};
        dir_rows = {dir_rows, untyped_row(mk_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                                  32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                                  32'h8000_0000, 32'hFFFF_FFFF, 1))};
        dir_rows = {dir_rows, untyped_row(mk_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                                  32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                                  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1))};
        // One step apart with huge masses and a tiny target: saturation.
        for (int k = 0; k < 4; k++)
            dir_rows = {dir_rows, untyped_row(mk_pair(1, 0, 0, 1, 0, 0, 0, 32'hFFFF_FFFF,
                                                      k == 0))};
        for (int k = 0; k < 4; k++)
            dir_rows = {dir_rows, untyped_row(mk_pair(0, 32'hFFFF_FFFF, 1, 1, 0, 0, 0,
                                                      32'hFFFF_FFFF, 0))};
        dir_rows = {dir_rows, untyped_row(mk_pair(32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F,
                                                  32'h8000_0000, 32'hF0F0_F0F0, 32'h5555_5555,
                                                  32'hAAAA_AAAA, 32'h7FFF_FFFF, 1))};

        g_list[0] = 32'hFFFF_FFFF;
        g_list[1] = 32'd0;
        g_list[2] = 32'd1;
        g_list[3] = $urandom;
        g_list[4] = 32'(G_DEFAULT_INT << FRAC);
        g_list[5] = $urandom >> $urandom_range(31);
        g_list[6] = 32'hFFFF_FFFF;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle = 20;
        recv_idle = 49;
        foreach (dir_rows[k]) pairs_to_send = {pairs_to_send, dir_rows[k]};
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_gravity(g_list[ph]);
            if (ph < 3) begin
                send_idle = 20;
                recv_idle = 49;
            end else if (ph < 5) begin
                send_idle = 49;
                recv_idle = 20;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
                pairs_to_send = {pairs_to_send, untyped_row(random_pair())};
            drain();
        end

        repeat (1200) @(posedge i_clk);
        if (n_fail == 0 && results_due.size() == 0) begin
            $display("tb_pairwise_gravity_accumulate_unit OK");
        end else begin
            $display("tb_pairwise_gravity_accumulate_unit NOT OK");
        end
        $finish;
    end

endmodule
